>>> design/pps_pkg.sv
// Package for the preemptive priority scheduler.
// Holds sizes, the job record type and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int TIME_BITS = 16;
    localparam int PRI_W     = 8;
    localparam int JOB_ID_W  = 4;
    localparam int IDLE_W    = 16;
    localparam int ACC_W     = 32;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 168;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [IDLE_W-1:0]    IDLE_MAX = {IDLE_W{1'b1}};

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] burst;
        logic [TIME_BITS-1:0] remaining;
        logic [PRI_W-1:0]     priority_num;
        logic [TIME_BITS-1:0] start;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_UPD,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_OUT
    } t_state;

endpackage

>>> design/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the job table of the scheduler. No dependencies.
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler top level: job table RAM, scan sequencer,
// compare unit and output register. Depends on pps_pkg and pps_ram.
//
//   channel   dir  fields
//   s_axis    in   tuser: opcode; tdata: arrival, burst, priority
//   m_axis    out  tdata: per-tick result and running totals
//
// A load is written straight into the job table. A tick scans the N loaded
// entries through the RAM read port, one entry a cycle, unless all jobs are
// done. A run passes S_FETCH and S_UPD, a finish also S_FIN1 to S_FIN3.
// Synchronous active-low reset clears counters, done flags and handshakes.
// A result waits in the output register while loads are still taken.
`timescale 1ns / 1ps

module preemptive_priority_scheduler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [15:0] arrival_time, [31:16] burst_length, [39:32] job_priority
    input  logic [pps_pkg::IN_W-1:0]   i_s_axis_tdata,
    // [0] opcode
    input  logic                       i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // [0] ran, [4:1] job_id, [20:5] time_after, [21] finished,
    // [37:22] completion_time, [53:38] turnaround, [69:54] waiting,
    // [85:70] response, [86] all_done, [102:87] idle_total,
    // [134:103] turnaround_sum, [166:135] waiting_sum, [167] zero
    output logic [pps_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    import pps_pkg::*;

    function automatic logic [TIME_BITS-1:0] sub_floor(input logic [TIME_BITS-1:0] a,
                                                       input logic [TIME_BITS-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [TIME_BITS-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W + 1)'(b);
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_job_count, r_done_count, r_idx;
    logic [MAX_JOBS-1:0]  r_done;
    logic [TIME_BITS-1:0] r_now;
    logic [IDLE_W-1:0]    r_idle;
    logic [ACC_W-1:0]     r_tacc, r_wacc;
    logic                 r_pend, r_best_v, r_ran, r_fin, r_ovalid;
    logic [IDX_W-1:0]     r_pidx, r_best_idx;
    logic [PRI_W-1:0]     r_best_pr;
    logic [TIME_BITS-1:0] r_best_arr;
    logic [TIME_BITS-1:0] r_arr, r_burst, r_start, r_tat, r_wait, r_resp;
    logic [OUT_W-1:0]     r_odata;

    logic                 s_accept, is_load, is_tick, ram_we, load_we, out_load;
    logic                 scan_end, eligible, better;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    t_job                 ram_wdata, ram_rdata, load_job, upd_job;
    logic [TIME_BITS-1:0] in_arr, in_burst, now_inc;
    logic [PRI_W-1:0]     in_pr;
    logic [JOB_ID_W-1:0]  out_jid;

    assign in_arr   = i_s_axis_tdata[15:0];
    assign in_burst = i_s_axis_tdata[31:16];
    assign in_pr    = i_s_axis_tdata[39:32];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign is_load  = s_accept && (t_op'(i_s_axis_tuser) == OP_LOAD);
    assign is_tick  = s_accept && (t_op'(i_s_axis_tuser) == OP_TICK);
    assign load_we  = is_load && (r_job_count < CNT_W'(MAX_JOBS));

    assign now_inc  = (r_now == TIME_MAX) ? r_now : r_now + 1'b1;
    assign scan_end = (r_idx == r_job_count) && !r_pend;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);

    assign eligible = !r_done[r_pidx] && (ram_rdata.arrival <= r_now);
    assign better   = !r_best_v || (ram_rdata.priority_num < r_best_pr) ||
                      ((ram_rdata.priority_num == r_best_pr) &&
                       (ram_rdata.arrival < r_best_arr));

    always_comb begin
        load_job.arrival      = in_arr;
        load_job.burst        = (in_burst == '0) ? TIME_BITS'(1) : in_burst;
        load_job.remaining    = load_job.burst;
        load_job.priority_num = in_pr;
        load_job.start        = '0;

        upd_job           = ram_rdata;
        upd_job.remaining = ram_rdata.remaining - 1'b1;
        if (ram_rdata.remaining == ram_rdata.burst) begin
            upd_job.start = r_now;
        end
    end

    assign ram_we    = load_we || (r_state == S_UPD);
    assign ram_waddr = (r_state == S_UPD) ? r_best_idx : r_job_count[IDX_W-1:0];
    assign ram_wdata = (r_state == S_UPD) ? upd_job : load_job;
    assign ram_raddr = (r_state == S_SCAN) ? r_idx[IDX_W-1:0] : r_best_idx;

    pps_ram #(
        .WIDTH (JOB_W),
        .DEPTH (MAX_JOBS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (is_tick) begin
                    n_state = (r_done_count >= r_job_count) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = r_best_v ? S_FETCH : S_OUT;
                end
            end
            S_FETCH: n_state = S_UPD;
            S_UPD:   n_state = (ram_rdata.remaining == TIME_BITS'(1)) ? S_FIN1 : S_OUT;
            S_FIN1:  n_state = S_FIN2;
            S_FIN2:  n_state = S_FIN3;
            S_FIN3:  n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_count  <= '0;
            r_done_count <= '0;
            r_done       <= '0;
            r_now        <= '0;
            r_idle       <= '0;
            r_tacc       <= '0;
            r_wacc       <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_best_v     <= 1'b0;
            r_ran        <= 1'b0;
            r_fin        <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (load_we) begin
                r_done[r_job_count[IDX_W-1:0]] <= 1'b0;
                r_job_count <= r_job_count + 1'b1;
            end
            if (is_tick) begin
                r_idx    <= '0;
                r_pend   <= 1'b0;
                r_best_v <= 1'b0;
                r_ran    <= 1'b0;
                r_fin    <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                if (r_idx != r_job_count) begin
                    r_idx  <= r_idx + 1'b1;
                    r_pidx <= r_idx[IDX_W-1:0];
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (r_pend && eligible && better) begin
                    r_best_v   <= 1'b1;
                    r_best_idx <= r_pidx;
                    r_best_pr  <= ram_rdata.priority_num;
                    r_best_arr <= ram_rdata.arrival;
                end
                if (scan_end && !r_best_v) begin
                    r_now <= now_inc;
                    if (r_idle != IDLE_MAX) begin
                        r_idle <= r_idle + 1'b1;
                    end
                end
            end
            if (r_state == S_UPD) begin
                r_ran   <= 1'b1;
                r_now   <= now_inc;
                r_fin   <= (ram_rdata.remaining == TIME_BITS'(1));
                r_arr   <= ram_rdata.arrival;
                r_burst <= ram_rdata.burst;
                r_start <= upd_job.start;
            end
            if (r_state == S_FIN1) begin
                r_tat  <= sub_floor(r_now, r_arr);
                r_resp <= sub_floor(r_start, r_arr);
                r_done[r_best_idx] <= 1'b1;
                r_done_count <= r_done_count + 1'b1;
            end
            if (r_state == S_FIN2) begin
                r_wait <= sub_floor(r_tat, r_burst);
                r_tacc <= sat_add(r_tacc, r_tat);
            end
            if (r_state == S_FIN3) begin
                r_wacc <= sat_add(r_wacc, r_wait);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign out_jid = r_ran ? JOB_ID_W'(r_best_idx) : '0;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= {1'b0,
                        r_wacc,
                        r_tacc,
                        r_idle,
                        (r_done_count >= r_job_count),
                        r_fin ? r_resp : '0,
                        r_fin ? r_wait : '0,
                        r_fin ? r_tat : '0,
                        r_fin ? r_now : '0,
                        r_fin,
                        r_now,
                        out_jid,
                        r_ran};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_count <= r_job_count)
        else $error("done count above job count");

    a_ram_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE || r_state == S_UPD))
        else $error("job table written outside load or update");

    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[21] |-> o_m_axis_tdata[0])
        else $error("finished without a run");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_tick |=> !o_s_axis_tready)
        else $error("ready right after a tick transfer");

    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN1) |=> r_done[$past(r_best_idx)])
        else $error("finished job not marked done");

endmodule

>>> dv/pps_schedule_checker.sv
`timescale 1ns / 1ps
// Schedule checker for the preemptive priority scheduler: watches both stream channels,
// keeps its own job table, predicts every tick report and compares it field by field.
// Depends on pps_pkg.

module pps_schedule_checker
    import pps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [OUT_W-1:0]  i_m_tdata,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int NUM_FIELDS = 12;

    typedef struct packed {
        logic [ACC_W-1:0]     waiting_sum;
        logic [ACC_W-1:0]     turnaround_sum;
        logic [IDLE_W-1:0]    idle_total;
        logic                 all_done;
        logic [TIME_BITS-1:0] response;
        logic [TIME_BITS-1:0] waiting;
        logic [TIME_BITS-1:0] turnaround;
        logic [TIME_BITS-1:0] completion_time;
        logic                 finished;
        logic [TIME_BITS-1:0] time_after;
        logic [JOB_ID_W-1:0]  job_id;
        logic                 ran;
    } t_tick_report;

    logic [TIME_BITS-1:0] arrival_tab [MAX_JOBS];
    logic [TIME_BITS-1:0] burst_tab   [MAX_JOBS];
    logic [TIME_BITS-1:0] remain_tab  [MAX_JOBS];
    logic [PRI_W-1:0]     prio_tab    [MAX_JOBS];
    logic [TIME_BITS-1:0] start_tab   [MAX_JOBS];
    bit                   done_tab    [MAX_JOBS];
    int                   job_cnt;
    int                   done_cnt;
    logic [TIME_BITS-1:0] now_t;
    logic [IDLE_W-1:0]    idle_cnt;
    logic [ACC_W-1:0]     tat_acc;
    logic [ACC_W-1:0]     wait_acc;
    t_tick_report         tick_reports [$];

    function automatic logic [TIME_BITS-1:0] floor_diff(input logic [TIME_BITS-1:0] a,
                                                        input logic [TIME_BITS-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic logic [ACC_W-1:0] sat_accumulate(input logic [ACC_W-1:0] acc,
                                                        input logic [TIME_BITS-1:0] x);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + (ACC_W + 1)'(x);
        return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    endfunction

    task automatic load_job(input logic [IN_W-1:0] fields);
        if (job_cnt < MAX_JOBS) begin
            arrival_tab[job_cnt] = fields[15:0];
            burst_tab[job_cnt]   = (fields[31:16] == '0) ? 16'd1 : fields[31:16];
            remain_tab[job_cnt]  = burst_tab[job_cnt];
            prio_tab[job_cnt]    = fields[39:32];
            start_tab[job_cnt]   = '0;
            done_tab[job_cnt]    = 1'b0;
            job_cnt++;
        end
    endtask

    function automatic t_tick_report advance_clock();
        t_tick_report r;
        int           best;
        int           i;
        r = '0;
        best = -1;
        if (done_cnt < job_cnt) begin
            for (i = 0; i < job_cnt; i++) begin
                if (!done_tab[i] && arrival_tab[i] <= now_t &&
                    (best < 0 || prio_tab[i] < prio_tab[best] ||
                     (prio_tab[i] == prio_tab[best] && arrival_tab[i] < arrival_tab[best])))
                    best = i;
            end
            if (best >= 0) begin
                r.ran    = 1'b1;
                r.job_id = JOB_ID_W'(best);
                if (remain_tab[best] == burst_tab[best])
                    start_tab[best] = now_t;
                remain_tab[best]--;
            end else if (idle_cnt != IDLE_MAX) begin
                idle_cnt++;
            end
            if (now_t != TIME_MAX)
                now_t++;
            if (best >= 0 && remain_tab[best] == '0) begin
                done_tab[best]    = 1'b1;
                done_cnt++;
                r.finished        = 1'b1;
                r.completion_time = now_t;
                r.turnaround      = floor_diff(now_t, arrival_tab[best]);
                r.waiting         = floor_diff(r.turnaround, burst_tab[best]);
                r.response        = floor_diff(start_tab[best], arrival_tab[best]);
                tat_acc           = sat_accumulate(tat_acc, r.turnaround);
                wait_acc          = sat_accumulate(wait_acc, r.waiting);
            end
        end
        r.time_after     = now_t;
        r.all_done       = (done_cnt >= job_cnt);
        r.idle_total     = idle_cnt;
        r.turnaround_sum = tat_acc;
        r.waiting_sum    = wait_acc;
        return r;
    endfunction

    function automatic int field_width(input int f);
        case (f)
            0, 3, 8: return 1;
            1:       return JOB_ID_W;
            9:       return IDLE_W;
            10, 11:  return ACC_W;
            default: return TIME_BITS;
        endcase
    endfunction

    function automatic string field_name(input int f);
        case (f)
            0:       return "ran";
            1:       return "job_id";
            2:       return "time_after";
            3:       return "finished";
            4:       return "completion_time";
            5:       return "turnaround";
            6:       return "waiting";
            7:       return "response";
            8:       return "all_done";
            9:       return "idle_total";
            10:      return "turnaround_sum";
            default: return "waiting_sum";
        endcase
    endfunction

    task automatic compare_report(input t_tick_report want, input logic [OUT_W-2:0] got);
        logic [OUT_W-2:0] want_vec;
        logic [ACC_W:0]   mask;
        logic [ACC_W-1:0] want_f;
        logic [ACC_W-1:0] got_f;
        int               lo;
        int               w;
        int               f;
        want_vec = want;
        lo = 0;
        for (f = 0; f < NUM_FIELDS; f++) begin
            w      = field_width(f);
            mask   = ((ACC_W + 1)'(1) << w) - 1'b1;
            want_f = ACC_W'(want_vec >> lo) & mask[ACC_W-1:0];
            got_f  = ACC_W'(got >> lo) & mask[ACC_W-1:0];
            if (want_f !== got_f) begin
                $display("%0t pps_schedule_checker: %s expected %0h actual %0h",
                         $time, field_name(f), want_f, got_f);
                o_fail_count++;
            end
            lo += w;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_JOBS; i++) begin
                arrival_tab[i] = '0;
                burst_tab[i]   = '0;
                remain_tab[i]  = '0;
                prio_tab[i]    = '0;
                start_tab[i]   = '0;
                done_tab[i]    = 1'b0;
            end
            job_cnt  = 0;
            done_cnt = 0;
            now_t    = '0;
            idle_cnt = '0;
            tat_acc  = '0;
            wait_acc = '0;
            tick_reports.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (tick_reports.size() == 0) begin
                    $display("%0t pps_schedule_checker: report with none expected, actual %h",
                             $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    compare_report(tick_reports.pop_front(), i_m_tdata[OUT_W-2:0]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_op'(i_s_tuser) == OP_TICK)
                    tick_reports.push_back(advance_clock());
                else
                    load_job(i_s_tdata);
            end
        end
        o_pending = tick_reports.size();
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the preemptive priority scheduler: clock, reset, job and tick
// stimulus with random idling on both channels, and the verdict.
// Depends on pps_pkg, the scheduler RTL and pps_schedule_checker.

module tb;
    import pps_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CALM_ITEMS   = 200;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tuser  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;
    int               cycles     = 0;
    int               loads_sent = 0;
    int               ticks_sent = 0;
    bit               idling_on  = 1'b1;

    always #4 clk = ~clk;

    preemptive_priority_scheduler dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    pps_schedule_checker sched_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic transfer_item(input t_op op, input logic [15:0] arrival,
                                 input logic [15:0] burst, input logic [7:0] prio);
        if (idling_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {prio, burst, arrival};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic issue_tick();
        transfer_item(OP_TICK, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)));
        ticks_sent++;
    endtask

    task automatic issue_load(input logic [15:0] arrival, input logic [15:0] burst,
                              input logic [7:0] prio);
        transfer_item(OP_LOAD, arrival, burst, prio);
        loads_sent++;
    endtask

    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 12);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 32);
            end
            repeat (n - 1) @(negedge clk);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty pool, zero burst, late high-priority arrival, priority and id ties
        issue_tick();
        issue_load(16'd1, 16'd0, 8'd0);
        issue_load(16'd0, 16'd3, 8'd255);
        issue_load(16'd0, 16'd1, 8'd255);
        repeat (6) issue_tick();
        // load after all done, idle ticks until arrival
        issue_load(16'd8, 16'd1, 8'd7);
        repeat (5) issue_tick();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                idling_on = 1'b0;
            if ($urandom_range(0, 7) != 0)
                issue_tick();
            else if (loads_sent == MAX_JOBS - 1)
                issue_load(16'(ticks_sent + $urandom_range(0, 24)), '1, '1);
            else
                issue_load(($urandom_range(0, 3) == 0) ? 16'($urandom_range(65528, 65535))
                                                       : 16'(ticks_sent + $urandom_range(0, 24)),
                           (loads_sent < MAX_JOBS) ? 16'($urandom_range(0, 15))
                                                   : 16'($urandom_range(0, 65535)),
                           $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                : 8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
